@@ hw/rtl/nqse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// N-queens enumerator package
// Widths, limits and sequencer state codes of the N-queens search block.
// ----------------------------------------------------------------------------
package nqse_pkg;

	localparam int MaxQueens  = 16;
	localparam int SizeW      = 5;
	localparam int RowW       = 4;
	localparam int ColW       = 4;
	localparam int CountW     = 24;
	localparam int PlacementW = MaxQueens * RowW;

	localparam logic [SizeW-1:0]  SizeReset = SizeW'(8);
	localparam logic [SizeW-1:0]  SizeMin   = SizeW'(1);
	localparam logic [SizeW-1:0]  SizeMax   = SizeW'(MaxQueens);
	localparam logic [CountW-1:0] CountMax  = {CountW{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_BACK   = 4'b0010,
		ST_CHECK  = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

endpackage

@@ hw/rtl/n_queens_solution_enumerator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// N-queens solution enumerator
// Backtracking search that returns the next N-queens solution per request.
// ----------------------------------------------------------------------------
// Each request (restart = 1 starts over, 0 continues) returns the next
// solution in lexicographic order of the row list, one 4-bit row per column,
// with a running solution count, or found = 0 once the search is exhausted.
// How long a request takes depends on the data. The sequencer accepts it,
// resumes a continued search one column back, tests every candidate square
// against the placed columns in turn (stopping early when an earlier column
// attacks it), steps back a column when a column runs out of rows, and
// loads the result. A continued request on an exhausted search goes straight
// to the result. A single row compare unit checks one earlier column per
// cycle against the candidate. The block takes no new request while
// searching; a finished result waits in the output register, and the
// sequencer holds it while that register is still full. Writing board_size
// clears the search, like a restart.
module n_queens_solution_enumerator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [nqse_pkg::SizeW-1:0]        board_size,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              restart,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              found,
	output logic [nqse_pkg::PlacementW-1:0]   placement,
	output logic [nqse_pkg::CountW-1:0]       solution_count
);

	nqse_pkg::state_t                state_q;
	logic [nqse_pkg::SizeW-1:0]      size_q;
	logic [nqse_pkg::SizeW-1:0]      n_eff;
	logic [nqse_pkg::RowW-1:0]       rows_q [nqse_pkg::MaxQueens];
	logic [nqse_pkg::SizeW-1:0]      depth_q;
	logic                            started_q;
	logic                            exh_q;
	logic [nqse_pkg::CountW-1:0]     count_q;
	logic [nqse_pkg::ColW-1:0]       d_q;
	logic [nqse_pkg::SizeW-1:0]      cand_q;
	logic [nqse_pkg::ColW-1:0]       k_q;
	logic                            res_found_q;

	logic                            out_valid_q;
	logic                            out_found_q;
	logic [nqse_pkg::PlacementW-1:0] out_place_q;
	logic [nqse_pkg::CountW-1:0]     out_count_q;

	logic [nqse_pkg::ColW-1:0]       rd_addr;
	logic [nqse_pkg::RowW-1:0]       rd_row;
	logic [nqse_pkg::RowW-1:0]       cand_lo;
	logic [nqse_pkg::RowW-1:0]       row_diff;
	logic [nqse_pkg::ColW-1:0]       col_gap;
	logic                            hit;
	logic                            cand_out;
	logic                            k_done;
	logic                            d_last;
	logic [nqse_pkg::SizeW-1:0]      d_start;
	logic                            accept;
	logic                            cfg_wr;
	logic                            out_load;
	logic                            place_en;
	logic [nqse_pkg::PlacementW-1:0] packed_rows;

	// clamp the board size into 1..MaxQueens
	always_comb begin
		if (size_q < nqse_pkg::SizeMin) begin
			n_eff = nqse_pkg::SizeMin;
		end else if (size_q > nqse_pkg::SizeMax) begin
			n_eff = nqse_pkg::SizeMax;
		end else begin
			n_eff = size_q;
		end
	end

	assign cfg_ready = (state_q == nqse_pkg::ST_IDLE);
	assign in_stall  = (state_q != nqse_pkg::ST_IDLE) || cfg_valid;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign accept    = in_valid && !in_stall;
	assign out_load  = (state_q == nqse_pkg::ST_RESULT) && (!out_valid_q || !out_stall);

	// row read port, shared by check and backtrack (result packing reads all rows directly)
	assign rd_addr  = (state_q == nqse_pkg::ST_BACK) ? d_q : k_q;
	assign rd_row   = rows_q[rd_addr];
	assign cand_lo  = cand_q[nqse_pkg::RowW-1:0];
	assign row_diff = (rd_row > cand_lo) ? (rd_row - cand_lo) : (cand_lo - rd_row);
	assign col_gap  = d_q - k_q;
	assign hit      = (rd_row == cand_lo) || (row_diff == col_gap);
	assign cand_out = (cand_q >= n_eff);
	assign k_done   = (k_q == d_q);
	assign d_last   = (({1'b0, d_q} + nqse_pkg::SizeW'(1)) == n_eff);
	assign d_start  = (depth_q > n_eff) ? n_eff : depth_q;
	assign place_en = (state_q == nqse_pkg::ST_CHECK) && !cand_out && k_done;

	always_comb begin
		for (int c = 0; c < nqse_pkg::MaxQueens; c++) begin
			packed_rows[c*nqse_pkg::RowW +: nqse_pkg::RowW] =
				(res_found_q && (nqse_pkg::SizeW'(c) < n_eff)) ? rows_q[c] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nqse_pkg::ST_IDLE;
			size_q      <= nqse_pkg::SizeReset;
			depth_q     <= '0;
			started_q   <= 1'b0;
			exh_q       <= 1'b0;
			count_q     <= '0;
			d_q         <= '0;
			cand_q      <= '0;
			k_q         <= '0;
			res_found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				nqse_pkg::ST_IDLE: begin
					if (cfg_wr) begin
						size_q    <= board_size;
						depth_q   <= '0;
						started_q <= 1'b0;
						exh_q     <= 1'b0;
						count_q   <= '0;
					end else if (accept) begin
						if (restart) begin
							depth_q <= '0;
							exh_q   <= 1'b0;
							count_q <= '0;
						end
						if (!restart && exh_q) begin
							res_found_q <= 1'b0;
							state_q     <= nqse_pkg::ST_RESULT;
						end else if (restart || !started_q) begin
							started_q <= 1'b1;
							d_q       <= '0;
							cand_q    <= '0;
							k_q       <= '0;
							state_q   <= nqse_pkg::ST_CHECK;
						end else if (d_start == '0) begin
							exh_q       <= 1'b1;
							res_found_q <= 1'b0;
							state_q     <= nqse_pkg::ST_RESULT;
						end else begin
							d_q     <= nqse_pkg::ColW'(d_start - nqse_pkg::SizeW'(1));
							state_q <= nqse_pkg::ST_BACK;
						end
					end
				end
				nqse_pkg::ST_BACK: begin
					// resume one column back, above the row it held
					cand_q  <= {1'b0, rd_row} + nqse_pkg::SizeW'(1);
					k_q     <= '0;
					state_q <= nqse_pkg::ST_CHECK;
				end
				nqse_pkg::ST_CHECK: begin
					if (cand_out) begin
						if (d_q == '0) begin
							depth_q     <= '0;
							exh_q       <= 1'b1;
							res_found_q <= 1'b0;
							state_q     <= nqse_pkg::ST_RESULT;
						end else begin
							d_q     <= d_q - nqse_pkg::ColW'(1);
							state_q <= nqse_pkg::ST_BACK;
						end
					end else if (!k_done) begin
						if (hit) begin
							cand_q <= cand_q + nqse_pkg::SizeW'(1);
							k_q    <= '0;
						end else begin
							k_q <= k_q + nqse_pkg::ColW'(1);
						end
					end else if (d_last) begin
						depth_q     <= n_eff;
						res_found_q <= 1'b1;
						if (count_q != nqse_pkg::CountMax) begin
							count_q <= count_q + nqse_pkg::CountW'(1);
						end
						state_q <= nqse_pkg::ST_RESULT;
					end else begin
						d_q    <= d_q + nqse_pkg::ColW'(1);
						cand_q <= '0;
						k_q    <= '0;
					end
				end
				nqse_pkg::ST_RESULT: begin
					if (out_load) begin
						state_q <= nqse_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= nqse_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (place_en) begin
			rows_q[d_q] <= cand_lo;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_found_q <= res_found_q;
			out_place_q <= packed_rows;
			out_count_q <= count_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = out_found_q;
	assign placement      = out_place_q;
	assign solution_count = out_count_q;

	a_check_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nqse_pkg::ST_CHECK) |-> (k_q <= d_q))
		else $error("compare index ran past the current column");

	a_found_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (solution_count != '0))
		else $error("solution given with zero count");

	a_exhausted_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (placement == '0))
		else $error("exhausted result carries a placement");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (!started_q && (depth_q == '0) && (count_q == '0)))
		else $error("board size write did not clear the search");

endmodule
